@@ design/d2s_pkg.sv @@
// Shared types and constants for the depth-to-space address generator.
// Used by the controller, the datapath, the register file and the top level.
package d2s_pkg;

  localparam int FIELD_W     = 24;  // width of the index result fields
  localparam int CFG_DATA_W  = 12;  // widest configuration register
  localparam int CFG_INDEX_W = 3;
  localparam int BLOCK_REG_W = 5;

  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_SIZE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MODE_CRD     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BATCH_COUNT  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_OUT_CHANNELS = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_IN_HEIGHT    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_IN_WIDTH     = 3'd5;

  // Steps of the shared multiply-add unit.
  typedef enum logic [2:0] {
    OP_BSQ,        // bs * bs
    OP_SUB,        // row_sub * bs + col_sub
    OP_IC,         // source channel
    OP_BATCH,      // batch_pos * out_channels
    OP_SCALE_BSQ,  // acc * bs^2 + channel
    OP_SCALE_H,    // acc * height + row_coarse
    OP_SCALE_W     // acc * width + col_coarse
  } op_t;

  typedef struct packed {
    logic clear;     // restart the walk
    logic mul_en;    // run one multiply-add step
    op_t  op;
    logic load_out;  // latch the result item and advance the walk
  } cmd_t;

endpackage

@@ design/depth_to_space_address_gen_unit.sv @@
// Top level of the depth-to-space address generator.
// Depends on d2s_pkg, d2s_cfg, d2s_ctrl and d2s_datapath.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid / in_ready   restart
//   out      output     out_valid / out_ready source_index, dest_index, is_last
//   cfg      input      cfg_we                cfg_index, cfg_data
//
// Each item passes from acceptance to its result in the output register
// through the accept step, seven steps of the single shared multiply-add
// unit that build the source index, and a step that loads the result.
// The next item is accepted in the cycle after the load, even if the result
// still waits in the output register. A stalled output holds the controller
// in its final step. Reset clears the walk to element zero and the
// registers to block size one, DCR order and all dimensions one.
module depth_to_space_address_gen_unit #(
  parameter int ADDR_BITS = 24,
  parameter int DIM_BITS  = 12,
  parameter int MAX_BLOCK = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            restart,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [d2s_pkg::FIELD_W-1:0]     source_index,
  output logic [d2s_pkg::FIELD_W-1:0]     dest_index,
  output logic                            is_last,
  input  logic                            cfg_we,
  input  logic [d2s_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [d2s_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int BW = $clog2(MAX_BLOCK + 1);

  d2s_pkg::cmd_t       cmd;
  logic [BW-1:0]       bs;
  logic                crd;
  logic [DIM_BITS-1:0] nb;
  logic [DIM_BITS-1:0] oc;
  logic [DIM_BITS-1:0] h;
  logic [DIM_BITS-1:0] w;

  d2s_cfg #(
    .DIM_BITS (DIM_BITS),
    .MAX_BLOCK(MAX_BLOCK)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .bs       (bs),
    .crd      (crd),
    .nb       (nb),
    .oc       (oc),
    .h        (h),
    .w        (w)
  );

  d2s_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .restart  (restart),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd)
  );

  d2s_datapath #(
    .ADDR_BITS(ADDR_BITS),
    .DIM_BITS (DIM_BITS),
    .MAX_BLOCK(MAX_BLOCK)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .bs          (bs),
    .crd         (crd),
    .nb          (nb),
    .oc          (oc),
    .h           (h),
    .w           (w),
    .source_index(source_index),
    .dest_index  (dest_index),
    .is_last     (is_last)
  );

endmodule

@@ design/d2s_cfg.sv @@
// Configuration registers of the depth-to-space address generator.
// Holds the raw register values and presents the clamped values. Uses d2s_pkg.
module d2s_cfg #(
  parameter int DIM_BITS  = 12,
  parameter int MAX_BLOCK = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [d2s_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [d2s_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic [$clog2(MAX_BLOCK+1)-1:0]      bs,
  output logic                                crd,
  output logic [DIM_BITS-1:0]                 nb,
  output logic [DIM_BITS-1:0]                 oc,
  output logic [DIM_BITS-1:0]                 h,
  output logic [DIM_BITS-1:0]                 w
);

  localparam int BW = $clog2(MAX_BLOCK + 1);
  localparam int RW = d2s_pkg::BLOCK_REG_W;

  logic [RW-1:0]       block_size;
  logic                mode_crd;
  logic [DIM_BITS-1:0] batch_count;
  logic [DIM_BITS-1:0] out_channels;
  logic [DIM_BITS-1:0] in_height;
  logic [DIM_BITS-1:0] in_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size   <= RW'(1);
      mode_crd     <= 1'b0;
      batch_count  <= DIM_BITS'(1);
      out_channels <= DIM_BITS'(1);
      in_height    <= DIM_BITS'(1);
      in_width     <= DIM_BITS'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        d2s_pkg::REG_BLOCK_SIZE:   block_size   <= cfg_data[RW-1:0];
        d2s_pkg::REG_MODE_CRD:     mode_crd     <= cfg_data[0];
        d2s_pkg::REG_BATCH_COUNT:  batch_count  <= DIM_BITS'(cfg_data);
        d2s_pkg::REG_OUT_CHANNELS: out_channels <= DIM_BITS'(cfg_data);
        d2s_pkg::REG_IN_HEIGHT:    in_height    <= DIM_BITS'(cfg_data);
        d2s_pkg::REG_IN_WIDTH:     in_width     <= DIM_BITS'(cfg_data);
        default: ;
      endcase
    end
  end

  // A zero block size or dimension acts as one; a large block size saturates.
  always_comb begin
    priority if (block_size == '0) begin
      bs = BW'(1);
    end else if (int'(block_size) > MAX_BLOCK) begin
      bs = BW'(MAX_BLOCK);
    end else begin
      bs = BW'(block_size);
    end
  end

  assign crd = mode_crd;
  assign nb  = (batch_count  == '0) ? DIM_BITS'(1) : batch_count;
  assign oc  = (out_channels == '0) ? DIM_BITS'(1) : out_channels;
  assign h   = (in_height    == '0) ? DIM_BITS'(1) : in_height;
  assign w   = (in_width     == '0) ? DIM_BITS'(1) : in_width;

endmodule

@@ design/d2s_ctrl.sv @@
// Controller of the depth-to-space address generator: sequences the multiply-add
// steps for one item and owns the output valid flag. Uses d2s_pkg.
module d2s_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          restart,
  output logic          out_valid,
  input  logic          out_ready,
  output d2s_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_BSQ,
    S_SUB,
    S_IC,
    S_BATCH,
    S_SCALE_BSQ,
    S_SCALE_H,
    S_SCALE_W,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   slot_free;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd          = '0;
    cmd.op       = d2s_pkg::OP_BSQ;
    cmd.clear    = accept && restart;
    state_next   = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_BSQ;
      end
      S_BSQ: begin
        cmd.mul_en = 1'b1;
        cmd.op     = d2s_pkg::OP_BSQ;
        state_next = S_SUB;
      end
      S_SUB: begin
        cmd.mul_en = 1'b1;
        cmd.op     = d2s_pkg::OP_SUB;
        state_next = S_IC;
      end
      S_IC: begin
        cmd.mul_en = 1'b1;
        cmd.op     = d2s_pkg::OP_IC;
        state_next = S_BATCH;
      end
      S_BATCH: begin
        cmd.mul_en = 1'b1;
        cmd.op     = d2s_pkg::OP_BATCH;
        state_next = S_SCALE_BSQ;
      end
      S_SCALE_BSQ: begin
        cmd.mul_en = 1'b1;
        cmd.op     = d2s_pkg::OP_SCALE_BSQ;
        state_next = S_SCALE_H;
      end
      S_SCALE_H: begin
        cmd.mul_en = 1'b1;
        cmd.op     = d2s_pkg::OP_SCALE_H;
        state_next = S_SCALE_W;
      end
      S_SCALE_W: begin
        cmd.mul_en = 1'b1;
        cmd.op     = d2s_pkg::OP_SCALE_W;
        state_next = S_DONE;
      end
      S_DONE: begin
        // Hold the finished index until the output register can take it.
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ design/d2s_datapath.sv @@
// Datapath of the depth-to-space address generator: walk position counters,
// one shared multiply-add unit and the output payload register. Uses d2s_pkg.
module d2s_datapath #(
  parameter int ADDR_BITS = 24,
  parameter int DIM_BITS  = 12,
  parameter int MAX_BLOCK = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  d2s_pkg::cmd_t                      cmd,
  input  logic [$clog2(MAX_BLOCK+1)-1:0]     bs,
  input  logic                               crd,
  input  logic [DIM_BITS-1:0]                nb,
  input  logic [DIM_BITS-1:0]                oc,
  input  logic [DIM_BITS-1:0]                h,
  input  logic [DIM_BITS-1:0]                w,
  output logic [d2s_pkg::FIELD_W-1:0]        source_index,
  output logic [d2s_pkg::FIELD_W-1:0]        dest_index,
  output logic                               is_last
);

  localparam int FW  = d2s_pkg::FIELD_W;
  // Only the low bits of an index reach the ports, so arithmetic stops there.
  localparam int SW  = (ADDR_BITS < FW) ? ADDR_BITS : FW;
  localparam int BW  = $clog2(MAX_BLOCK + 1);
  localparam int SBW = $clog2(MAX_BLOCK);

  logic [DIM_BITS-1:0] batch_pos;
  logic [DIM_BITS-1:0] chan_pos;
  logic [DIM_BITS-1:0] row_coarse;
  logic [SBW-1:0]      row_sub;
  logic [DIM_BITS-1:0] col_coarse;
  logic [SBW-1:0]      col_sub;
  logic [SW-1:0]       dest_counter;

  logic [SW-1:0] bsq;
  logic [SW-1:0] sub;
  logic [SW-1:0] ic;
  logic [SW-1:0] acc;
  logic [SW-1:0] mul_a;
  logic [SW-1:0] mul_b;
  logic [SW-1:0] add_c;
  logic [SW-1:0] mac;

  logic [SW-1:0] out_src;
  logic [SW-1:0] out_dest;
  logic          out_last;

  logic e_col_sub, e_col_coarse, e_row_sub, e_row_coarse, e_chan, e_batch;
  logic c1, c2, c3, c4, c5, last;

  function automatic logic end_dim(input logic [DIM_BITS-1:0] pos,
                                   input logic [DIM_BITS-1:0] lim);
    return ({1'b0, pos} + (DIM_BITS + 1)'(1)) >= {1'b0, lim};
  endfunction

  function automatic logic end_sub(input logic [SBW-1:0] pos,
                                   input logic [BW-1:0] lim);
    return (int'(pos) + 1) >= int'(lim);
  endfunction

  // Shared multiply-add: one product per cycle while a step is commanded, registered before reuse.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    add_c = '0;
    unique case (cmd.op)
      d2s_pkg::OP_BSQ: begin
        mul_a = SW'(bs);
        mul_b = SW'(bs);
      end
      d2s_pkg::OP_SUB: begin
        mul_a = SW'(row_sub);
        mul_b = SW'(bs);
        add_c = SW'(col_sub);
      end
      d2s_pkg::OP_IC: begin
        if (crd) begin
          mul_a = SW'(chan_pos);
          mul_b = bsq;
          add_c = sub;
        end else begin
          mul_a = sub;
          mul_b = SW'(oc);
          add_c = SW'(chan_pos);
        end
      end
      d2s_pkg::OP_BATCH: begin
        mul_a = SW'(batch_pos);
        mul_b = SW'(oc);
      end
      d2s_pkg::OP_SCALE_BSQ: begin
        mul_a = acc;
        mul_b = bsq;
        add_c = ic;
      end
      d2s_pkg::OP_SCALE_H: begin
        mul_a = acc;
        mul_b = SW'(h);
        add_c = SW'(row_coarse);
      end
      d2s_pkg::OP_SCALE_W: begin
        mul_a = acc;
        mul_b = SW'(w);
        add_c = SW'(col_coarse);
      end
      default: ;
    endcase
    mac = mul_a * mul_b + add_c;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      unique case (cmd.op)
        d2s_pkg::OP_BSQ: bsq <= mac;
        d2s_pkg::OP_SUB: sub <= mac;
        d2s_pkg::OP_IC:  ic  <= mac;
        default:         acc <= mac;
      endcase
    end
    if (cmd.load_out) begin
      out_src  <= acc;
      out_dest <= dest_counter;
      out_last <= last;
    end
  end

  // The walk advances like an odometer: each counter moves only when all
  // faster counters wrap.
  assign e_col_sub    = end_sub(col_sub, bs);
  assign e_col_coarse = end_dim(col_coarse, w);
  assign e_row_sub    = end_sub(row_sub, bs);
  assign e_row_coarse = end_dim(row_coarse, h);
  assign e_chan       = end_dim(chan_pos, oc);
  assign e_batch      = end_dim(batch_pos, nb);

  assign c1   = e_col_sub;
  assign c2   = c1 && e_col_coarse;
  assign c3   = c2 && e_row_sub;
  assign c4   = c3 && e_row_coarse;
  assign c5   = c4 && e_chan;
  assign last = c5 && e_batch;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      batch_pos    <= '0;
      chan_pos     <= '0;
      row_coarse   <= '0;
      row_sub      <= '0;
      col_coarse   <= '0;
      col_sub      <= '0;
      dest_counter <= '0;
    end else if (cmd.load_out) begin
      col_sub <= e_col_sub ? '0 : col_sub + SBW'(1);
      if (c1) col_coarse <= e_col_coarse ? '0 : col_coarse + DIM_BITS'(1);
      if (c2) row_sub    <= e_row_sub ? '0 : row_sub + SBW'(1);
      if (c3) row_coarse <= e_row_coarse ? '0 : row_coarse + DIM_BITS'(1);
      if (c4) chan_pos   <= e_chan ? '0 : chan_pos + DIM_BITS'(1);
      if (c5) batch_pos  <= e_batch ? '0 : batch_pos + DIM_BITS'(1);
      dest_counter <= last ? '0 : dest_counter + SW'(1);
    end
  end

  assign source_index = FW'(out_src);
  assign dest_index   = FW'(out_dest);
  assign is_last      = out_last;

endmodule

@@ design/d2s_checker.sv @@
// Port-level checks for the depth-to-space address generator, bound to the top.
// Depends on d2s_pkg and depth_to_space_address_gen_unit.
module d2s_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [d2s_pkg::FIELD_W-1:0] source_index,
  input logic [d2s_pkg::FIELD_W-1:0] dest_index,
  input logic                        is_last
);

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(source_index) &&
      $stable(dest_index) && $stable(is_last))
    else $error("result item changed while stalled");

  // The block works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while busy");

  // Coming back ready means the finished result is in the output register.
  a_ready_with_result: assert property (@(posedge clk) disable iff (rst)
    $rose(in_ready) |-> out_valid)
    else $error("ready again without a result item");

  // A result only leaves when it is taken.
  a_out_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> $past(out_ready))
    else $error("result item dropped without being taken");

endmodule

bind depth_to_space_address_gen_unit d2s_checker u_d2s_checker (.*);
